// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TLQE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TLQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TLQE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TLQE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/tlqe_pkg.sv
// ---------------------------------------------------------------------------
// tlqe_pkg
// Widths, register indexes and shared types of the thick line quad expander.
// ---------------------------------------------------------------------------
package tlqe_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CW    = 32;   // coordinate width
    localparam int THW   = 24;   // thickness width
    localparam int ZW    = 24;   // zoom width
    localparam int COLW  = 8;    // color channel width
    localparam int SQW   = 64;   // radicand width
    localparam int RTW   = 32;   // root width
    localparam int NUMW  = 56;   // dividend width
    localparam int DENW  = 33;   // divisor width
    localparam int QW    = 24;   // quotient width

    localparam int IN_DW  = 176;
    localparam int OUT_DW = 88;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] REG_CAM_X = 2'd0;
    localparam logic [CFG_IW-1:0] REG_CAM_Y = 2'd1;
    localparam logic [CFG_IW-1:0] REG_ZOOM  = 2'd2;

    localparam logic [ZW-1:0] ZOOM_RST = 24'd65536;

    // screen corners of one segment plus color and a zero-length flag, handed to the vertex emitter
    typedef struct packed {
        logic [3:0][CW-1:0] px;
        logic [3:0][CW-1:0] py;
        logic [COLW-1:0]    red;
        logic [COLW-1:0]    green;
        logic [COLW-1:0]    blue;
        logic               zero;
    } t_quad;

endpackage

// File: rtl/tlqe_sqrt.sv
// ---------------------------------------------------------------------------
// tlqe_sqrt
// Pipelined integer square root, one root bit per stage, with side payload.
// ---------------------------------------------------------------------------
module tlqe_sqrt #(
    parameter int PW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [tlqe_pkg::SQW-1:0]  i_rad,
    input  logic [PW-1:0]             i_pay,
    output logic                      o_valid,
    output logic [tlqe_pkg::RTW-1:0]  o_root,
    output logic [PW-1:0]             o_pay
);
    import tlqe_pkg::*;

    localparam int NS  = RTW;
    localparam int REW = RTW + 2;

    logic            r_v    [NS];
    logic [SQW-1:0]  r_rad  [NS];
    logic [REW-1:0]  r_rem  [NS];
    logic [RTW-1:0]  r_root [NS];
    logic [PW-1:0]   r_pay  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_st
        localparam int J = NS - 1 - k;
        logic            a_v;
        logic [SQW-1:0]  a_rad;
        logic [REW-1:0]  a_rem;
        logic [RTW-1:0]  a_root;
        logic [PW-1:0]   a_pay;
        logic [REW+1:0]  a_t;
        logic [REW+1:0]  a_trial;
        logic            a_ge;

        if (k == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_rad  = i_rad;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_pay  = i_pay;
        end else begin : g_next
            assign a_v    = r_v[k-1];
            assign a_rad  = r_rad[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_pay  = r_pay[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign a_t     = {a_rem, a_rad[2*J+1 -: 2]};
        assign a_trial = {2'b00, a_root, 2'b01};
        assign a_ge    = (a_t >= a_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= a_rad;
                r_pay[k]  <= a_pay;
                r_rem[k]  <= a_ge ? REW'(a_t - a_trial) : a_t[REW-1:0];
                r_root[k] <= {a_root[RTW-2:0], a_ge};
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_pay   = r_pay[NS-1];

endmodule

// File: rtl/tlqe_div.sv
// ---------------------------------------------------------------------------
// tlqe_div
// Dual pipelined restoring divider sharing one divisor, one quotient bit
// per stage. The quotient is known to fit in QW bits.
// ---------------------------------------------------------------------------
module tlqe_div #(
    parameter int PW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [tlqe_pkg::NUMW-1:0]  i_num_x,
    input  logic [tlqe_pkg::NUMW-1:0]  i_num_y,
    input  logic [tlqe_pkg::DENW-1:0]  i_den,
    input  logic [PW-1:0]              i_pay,
    output logic                       o_valid,
    output logic [tlqe_pkg::QW-1:0]    o_q_x,
    output logic [tlqe_pkg::QW-1:0]    o_q_y,
    output logic [PW-1:0]              o_pay
);
    import tlqe_pkg::*;

    logic             r_v   [QW];
    logic [NUMW-1:0]  r_rx  [QW];
    logic [NUMW-1:0]  r_ry  [QW];
    logic [DENW-1:0]  r_den [QW];
    logic [QW-1:0]    r_qx  [QW];
    logic [QW-1:0]    r_qy  [QW];
    logic [PW-1:0]    r_pay [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        localparam int SH = QW - 1 - k;
        logic             a_v;
        logic [NUMW-1:0]  a_rx;
        logic [NUMW-1:0]  a_ry;
        logic [DENW-1:0]  a_den;
        logic [QW-1:0]    a_qx;
        logic [QW-1:0]    a_qy;
        logic [PW-1:0]    a_pay;
        logic [NUMW:0]    a_dsh;
        logic             a_gx;
        logic             a_gy;

        if (k == 0) begin : g_first
            assign a_v   = i_valid;
            assign a_rx  = i_num_x;
            assign a_ry  = i_num_y;
            assign a_den = i_den;
            assign a_qx  = '0;
            assign a_qy  = '0;
            assign a_pay = i_pay;
        end else begin : g_next
            assign a_v   = r_v[k-1];
            assign a_rx  = r_rx[k-1];
            assign a_ry  = r_ry[k-1];
            assign a_den = r_den[k-1];
            assign a_qx  = r_qx[k-1];
            assign a_qy  = r_qy[k-1];
            assign a_pay = r_pay[k-1];
        end

        // compare against the divisor aligned to this quotient bit
        assign a_dsh = (NUMW+1)'(a_den) << SH;
        assign a_gx  = ({1'b0, a_rx} >= a_dsh);
        assign a_gy  = ({1'b0, a_ry} >= a_dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= a_den;
                r_pay[k] <= a_pay;
                r_rx[k]  <= a_gx ? (a_rx - a_dsh[NUMW-1:0]) : a_rx;
                r_ry[k]  <= a_gy ? (a_ry - a_dsh[NUMW-1:0]) : a_ry;
                r_qx[k]  <= {a_qx[QW-2:0], a_gx};
                r_qy[k]  <= {a_qy[QW-2:0], a_gy};
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q_x   = r_qx[QW-1];
    assign o_q_y   = r_qy[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule

// File: rtl/tlqe_emit.sv
// ---------------------------------------------------------------------------
// tlqe_emit
// Output sequencer: holds one quad and sends its six vertices A,B,C,A,C,D.
// ---------------------------------------------------------------------------
module tlqe_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  tlqe_pkg::t_quad               i_quad,
    output logic                          o_free,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    // tdata: vertex_x, vertex_y, out_red, out_green, out_blue (low bit up)
    output logic [tlqe_pkg::OUT_DW-1:0]   o_tdata,
    output logic                          o_tlast
);
    import tlqe_pkg::*;

    localparam logic [2:0] LAST_VTX = 3'd5;

    logic        r_busy;
    logic [2:0]  r_idx;
    t_quad       r_quad;
    logic [1:0]  w_corner;
    logic        w_take;

    assign w_take = r_busy && i_tready;
    assign o_free = !r_busy || (w_take && (r_idx == LAST_VTX));

    // sequence control; a zero-length segment leaves the emitter empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= !i_quad.zero;
            r_idx  <= '0;
        end else if (w_take) begin
            if (r_idx == LAST_VTX) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quad <= i_quad;
        end
    end

    // vertex order of the two triangles
    always_comb begin
        case (r_idx)
            3'd0:    w_corner = 2'd0;
            3'd1:    w_corner = 2'd1;
            3'd2:    w_corner = 2'd2;
            3'd3:    w_corner = 2'd0;
            3'd4:    w_corner = 2'd2;
            3'd5:    w_corner = 2'd3;
            default: w_corner = 2'd0;
        endcase
    end

    assign o_tvalid = r_busy;
    assign o_tlast  = (r_idx == LAST_VTX);
    assign o_tdata  = {r_quad.blue, r_quad.green, r_quad.red,
                       r_quad.py[w_corner], r_quad.px[w_corner]};

endmodule

// File: rtl/thick_line_quad_expander_core.sv
// ---------------------------------------------------------------------------
// thick_line_quad_expander_core
// Expands a world-space line segment into two screen-space triangles.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one item per segment, tdata holds start/end
//   points, thickness and color. Output stream (m_axis): six vertex items
//   per segment in order A,B,C,A,C,D; tlast marks the sixth. A zero-length
//   segment produces no vertex.
//   Configuration: write camera_x (0), camera_y (1) or zoom (2) through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
//   Pipeline: a segment passes 7 front stages, 32 square-root stages, 1
//   multiply stage, 24 divider stages and 5 screen-mapping stages, then
//   loads into the emitter, which sends its first vertex.
//   Throughput: the single vertex output port bounds the segment rate, as
//   each segment takes six vertex items; a segment enters every cycle while
//   the pipeline has room, and a zero-length segment leaves the emitter free.
//   Reset: synchronous, active low; clears all valid bits and sets camera to
//   0 and zoom to 1.0.
//   Stall: a receiver stall with a segment in the final stage freezes the
//   whole pipeline behind the emitter; o_s_axis_tready drops, nothing is lost.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module thick_line_quad_expander_core #(
    parameter int FRAC_BITS = tlqe_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y, thickness, red, green, blue
    input  logic [tlqe_pkg::IN_DW-1:0]    i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: vertex_x, vertex_y, out_red, out_green, out_blue
    output logic [tlqe_pkg::OUT_DW-1:0]   o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [tlqe_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [tlqe_pkg::CW-1:0]       i_cfg_data
);
    import tlqe_pkg::*;

    localparam logic [63:0] ZLIM =
        ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000000000;
    localparam logic [58:0] RND_HALF = 59'd1 << (FRAC_BITS - 1);
    localparam int SQ_PW = 4*CW + THW + 3*COLW + 3 + 2*CW;
    localparam int DV_PW = 4*CW + 3*COLW + 3;

    // configuration registers
    logic signed [CW-1:0] r_cam_x;
    logic signed [CW-1:0] r_cam_y;
    logic [ZW-1:0]        r_zoom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_zoom  <= ZOOM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAM_X: r_cam_x <= i_cfg_data;
                REG_CAM_Y: r_cam_y <= i_cfg_data;
                REG_ZOOM:  r_zoom  <= i_cfg_data[ZW-1:0];
                default:   ;
            endcase
        end
    end

    // global advance: everything moves unless the last stage is blocked
    logic w_en;
    logic w_free;
    logic w_load;
    logic r_v14;

    assign w_en            = !r_v14 || w_free;
    assign w_load          = r_v14 && w_free;
    assign o_s_axis_tready = w_en;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic r_v10, r_v11, r_v12, r_v13;
    logic w_sq_v, w_dv_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0; r_v2  <= 1'b0; r_v3  <= 1'b0; r_v4  <= 1'b0;
            r_v5  <= 1'b0; r_v6  <= 1'b0; r_v7  <= 1'b0; r_v8  <= 1'b0;
            r_v10 <= 1'b0; r_v11 <= 1'b0; r_v12 <= 1'b0; r_v13 <= 1'b0;
            r_v14 <= 1'b0;
        end else if (w_en) begin
            r_v1  <= i_s_axis_tvalid;
            r_v2  <= r_v1;  r_v3  <= r_v2;  r_v4  <= r_v3;
            r_v5  <= r_v4;  r_v6  <= r_v5;  r_v7  <= r_v6;
            r_v8  <= w_sq_v;
            r_v10 <= w_dv_v;
            r_v11 <= r_v10; r_v12 <= r_v11; r_v13 <= r_v12; r_v14 <= r_v13;
        end
    end

    // segment payload carried through the front stages
    logic [4*CW-1:0]   r_pts1, r_pts2, r_pts3, r_pts4, r_pts5, r_pts6, r_pts7;
    logic [THW-1:0]    r_th1, r_th2, r_th3, r_th4, r_th5, r_th6, r_th7;
    logic [3*COLW-1:0] r_col1, r_col2, r_col3, r_col4, r_col5, r_col6, r_col7;

    // stage 1: differences
    logic signed [CW:0] r_dx1, r_dy1;
    logic signed [CW-1:0] w_sx, w_sy, w_ex, w_ey;

    assign w_sx = i_s_axis_tdata[31:0];
    assign w_sy = i_s_axis_tdata[63:32];
    assign w_ex = i_s_axis_tdata[95:64];
    assign w_ey = i_s_axis_tdata[127:96];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts1 <= i_s_axis_tdata[127:0];
            r_th1  <= i_s_axis_tdata[151:128];
            r_col1 <= i_s_axis_tdata[175:152];
            r_dx1  <= (CW+1)'(w_ex) - (CW+1)'(w_sx);
            r_dy1  <= (CW+1)'(w_ey) - (CW+1)'(w_sy);
        end
    end

    // stage 2: magnitudes and normal signs
    logic [CW:0] r_adx2, r_ady2;
    logic [2:0]  r_fl2, r_fl3, r_fl4, r_fl5, r_fl6, r_fl7;   // zero, dy_pos, dx_neg

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts2 <= r_pts1; r_th2 <= r_th1; r_col2 <= r_col1;
            r_adx2 <= r_dx1[CW] ? (CW+1)'(-r_dx1) : r_dx1;
            r_ady2 <= r_dy1[CW] ? (CW+1)'(-r_dy1) : r_dy1;
            r_fl2  <= {1'b0, (!r_dy1[CW] && (r_dy1 != '0)), r_dx1[CW]};
        end
    end

    // stage 3: maximum and small-case squares for the zero test
    logic [CW:0]     r_adx3, r_ady3;
    logic            r_big3;
    logic [CW-2:0]   r_m3;
    logic [2*CW-3:0] r_sqx3, r_sqy3;
    logic [CW:0]     w_m2;

    assign w_m2 = (r_adx2 > r_ady2) ? r_adx2 : r_ady2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts3 <= r_pts2; r_th3 <= r_th2; r_col3 <= r_col2; r_fl3 <= r_fl2;
            r_adx3 <= r_adx2;
            r_ady3 <= r_ady2;
            r_big3 <= w_m2[CW] | w_m2[CW-1];
            r_m3   <= w_m2[CW-2:0];
            r_sqx3 <= r_adx2[CW-2:0] * r_adx2[CW-2:0];
            r_sqy3 <= r_ady2[CW-2:0] * r_ady2[CW-2:0];
        end
    end

    // stage 4: zero test, coarse normalize by 16 and 8
    logic [CW-2:0] r_m4, r_ax4, r_ay4;
    logic [CW-1:0] r_axb4, r_ayb4;
    logic          r_big4;
    logic [CW-2:0] w_ma, w_xa, w_ya, w_mb, w_xb, w_yb;
    logic [63:0]   w_sq3;

    always_comb begin
        w_sq3 = 64'(r_sqx3) + 64'(r_sqy3);
        w_ma  = r_m3;
        w_xa  = r_adx3[CW-2:0];
        w_ya  = r_ady3[CW-2:0];
        if (w_ma[CW-2 -: 16] == '0) begin
            w_ma = w_ma << 16; w_xa = w_xa << 16; w_ya = w_ya << 16;
        end
        w_mb = w_ma; w_xb = w_xa; w_yb = w_ya;
        if (w_mb[CW-2 -: 8] == '0) begin
            w_mb = w_mb << 8; w_xb = w_xb << 8; w_yb = w_yb << 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts4 <= r_pts3; r_th4 <= r_th3; r_col4 <= r_col3;
            r_fl4  <= {(!r_big3 && (w_sq3 <= ZLIM)), r_fl3[1:0]};
            r_big4 <= r_big3;
            r_axb4 <= r_adx3[CW:1];
            r_ayb4 <= r_ady3[CW:1];
            r_m4   <= w_mb;
            r_ax4  <= w_xb;
            r_ay4  <= w_yb;
        end
    end

    // stage 5: fine normalize by 4, 2, 1, or halve a large direction
    logic [CW-1:0] r_ax5, r_ay5;
    logic [CW-2:0] w_mc, w_xc, w_yc;

    always_comb begin
        w_mc = r_m4; w_xc = r_ax4; w_yc = r_ay4;
        if (w_mc[CW-2 -: 4] == '0) begin
            w_mc = w_mc << 4; w_xc = w_xc << 4; w_yc = w_yc << 4;
        end
        if (w_mc[CW-2 -: 2] == '0) begin
            w_mc = w_mc << 2; w_xc = w_xc << 2; w_yc = w_yc << 2;
        end
        if (!w_mc[CW-2]) begin
            w_xc = w_xc << 1; w_yc = w_yc << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts5 <= r_pts4; r_th5 <= r_th4; r_col5 <= r_col4; r_fl5 <= r_fl4;
            r_ax5  <= r_big4 ? r_axb4 : {1'b0, w_xc};
            r_ay5  <= r_big4 ? r_ayb4 : {1'b0, w_yc};
        end
    end

    // stage 6: squares of the scaled direction
    logic [CW-1:0]  r_ax6, r_ay6, r_ax7, r_ay7;
    logic [SQW-1:0] r_sqx6, r_sqy6, r_rad7;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts6 <= r_pts5; r_th6 <= r_th5; r_col6 <= r_col5; r_fl6 <= r_fl5;
            r_ax6  <= r_ax5;
            r_ay6  <= r_ay5;
            r_sqx6 <= r_ax5 * r_ax5;
            r_sqy6 <= r_ay5 * r_ay5;
        end
    end

    // stage 7: radicand
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts7 <= r_pts6; r_th7 <= r_th6; r_col7 <= r_col6; r_fl7 <= r_fl6;
            r_ax7  <= r_ax6;
            r_ay7  <= r_ay6;
            r_rad7 <= r_sqx6 + r_sqy6;
        end
    end

    // length
    logic [RTW-1:0]  w_len;
    logic [SQ_PW-1:0] w_sq_pay;
    logic [4*CW-1:0]  w_pts8;
    logic [THW-1:0]   w_th8;
    logic [3*COLW-1:0] w_col8;
    logic [2:0]       w_fl8;
    logic [CW-1:0]    w_ax8, w_ay8;

    tlqe_sqrt #(.PW(SQ_PW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v7),
        .i_rad   (r_rad7),
        .i_pay   ({r_pts7, r_th7, r_col7, r_fl7, r_ax7, r_ay7}),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_pay   (w_sq_pay)
    );

    assign {w_pts8, w_th8, w_col8, w_fl8, w_ax8, w_ay8} = w_sq_pay;

    // stage 8: numerators' products
    logic [NUMW-1:0]   r_px8, r_py8;
    logic [RTW-1:0]    r_len8;
    logic [4*CW-1:0]   r_pts8;
    logic [3*COLW-1:0] r_col8;
    logic [2:0]        r_fl8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pts8 <= w_pts8; r_col8 <= w_col8; r_fl8 <= w_fl8;
            r_len8 <= w_len;
            r_px8  <= w_ay8 * w_th8;
            r_py8  <= w_ax8 * w_th8;
        end
    end

    // normal magnitudes, rounded: (a*thick + len) / (2*len)
    logic [QW-1:0]     w_qx, w_qy;
    logic [DV_PW-1:0]  w_dv_pay;
    logic [4*CW-1:0]   w_pts10;
    logic [3*COLW-1:0] w_col10;
    logic [2:0]        w_fl10;

    tlqe_div #(.PW(DV_PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v8),
        .i_num_x (r_px8 + NUMW'(r_len8)),
        .i_num_y (r_py8 + NUMW'(r_len8)),
        .i_den   ({r_len8, 1'b0}),
        .i_pay   ({r_pts8, r_col8, r_fl8}),
        .o_valid (w_dv_v),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy),
        .o_pay   (w_dv_pay)
    );

    assign {w_pts10, w_col10, w_fl10} = w_dv_pay;

    // stage 10: world corners; entries 0..3 are x of A..D, 4..7 are y
    logic signed [CW+1:0] r_w10 [8];
    logic [3*COLW-1:0]    r_col10, r_col11, r_col12, r_col13, r_col14;
    logic                 r_z10, r_z11, r_z12, r_z13, r_z14;
    logic signed [CW+1:0] w_s34x, w_s34y, w_e34x, w_e34y, w_qx34, w_qy34;

    assign w_s34x = (CW+2)'($signed(w_pts10[31:0]));
    assign w_s34y = (CW+2)'($signed(w_pts10[63:32]));
    assign w_e34x = (CW+2)'($signed(w_pts10[95:64]));
    assign w_e34y = (CW+2)'($signed(w_pts10[127:96]));
    assign w_qx34 = (CW+2)'(w_qx);
    assign w_qy34 = (CW+2)'(w_qy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col10 <= w_col10;
            r_z10   <= w_fl10[2];
            // normal x points against dy, normal y along dx
            r_w10[0] <= w_fl10[1] ? w_s34x - w_qx34 : w_s34x + w_qx34;
            r_w10[1] <= w_fl10[1] ? w_e34x - w_qx34 : w_e34x + w_qx34;
            r_w10[2] <= w_fl10[1] ? w_e34x + w_qx34 : w_e34x - w_qx34;
            r_w10[3] <= w_fl10[1] ? w_s34x + w_qx34 : w_s34x - w_qx34;
            r_w10[4] <= w_fl10[0] ? w_s34y - w_qy34 : w_s34y + w_qy34;
            r_w10[5] <= w_fl10[0] ? w_e34y - w_qy34 : w_e34y + w_qy34;
            r_w10[6] <= w_fl10[0] ? w_e34y + w_qy34 : w_e34y - w_qy34;
            r_w10[7] <= w_fl10[0] ? w_s34y + w_qy34 : w_s34y - w_qy34;
        end
    end

    // stages 11..14: camera offset, magnitude, zoom, rounding
    logic signed [CW+2:0] r_d11  [8];
    logic [CW+1:0]        r_mag12[8];
    logic [7:0]           r_neg12, r_neg13, r_neg14;
    logic [CW+ZW+1:0]     r_p13  [8];
    logic [58:0]          r_r14  [8];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col11 <= r_col10; r_col12 <= r_col11;
            r_col13 <= r_col12; r_col14 <= r_col13;
            r_z11   <= r_z10;   r_z12   <= r_z11;
            r_z13   <= r_z12;   r_z14   <= r_z13;
            r_neg13 <= r_neg12; r_neg14 <= r_neg13;
            for (int k = 0; k < 8; k++) begin
                r_d11[k]   <= (CW+3)'(r_w10[k])
                            - (CW+3)'((k < 4) ? r_cam_x : r_cam_y);
                r_neg12[k] <= r_d11[k][CW+2];
                r_mag12[k] <= r_d11[k][CW+2] ? (CW+2)'(-r_d11[k])
                                             : r_d11[k][CW+1:0];
                r_p13[k]   <= r_mag12[k] * r_zoom;
                r_r14[k]   <= (59'(r_p13[k]) + RND_HALF) >> FRAC_BITS;
            end
        end
    end

    // saturate to the signed coordinate range and restore the sign
    t_quad            w_quad;
    logic [CW-1:0]    w_scr [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (r_neg14[k]) begin
                w_scr[k] = (r_r14[k] > 59'h80000000) ? 32'h80000000
                                                     : 32'(0 - r_r14[k][CW-1:0]);
            end else begin
                w_scr[k] = (r_r14[k] > 59'h7FFFFFFF) ? 32'h7FFFFFFF
                                                     : r_r14[k][CW-1:0];
            end
        end
        for (int c = 0; c < 4; c++) begin
            w_quad.px[c] = w_scr[c];
            w_quad.py[c] = w_scr[c+4];
        end
        w_quad.red   = r_col14[7:0];
        w_quad.green = r_col14[15:8];
        w_quad.blue  = r_col14[23:16];
        w_quad.zero  = r_z14;
    end

    tlqe_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_quad   (w_quad),
        .o_free   (w_free),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    // a new segment always starts at vertex A, never directly at the last
    `TLQE_ASSERT_NEXT(a_last_spacing, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tlast && i_m_axis_tready,
        !(o_m_axis_tvalid && o_m_axis_tlast))
    // a blocked final stage must hold off intake
    `TLQE_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n,
        r_v14 && !w_free, !o_s_axis_tready)
    // a frozen pipeline keeps its finished segment
    `TLQE_ASSERT_NEXT(a_stall_keeps_item, i_clk, i_rst_n,
        r_v14 && !w_en, r_v14)

endmodule

// File: sim/thick_line_quad_expander_core_test.sv
// ---------------------------------------------------------------------------
// thick_line_quad_expander_core_test
// Drives line segments through the quad expander and checks every vertex
// against a fixed point predictor, over several camera and zoom settings.
// ---------------------------------------------------------------------------
module thick_line_quad_expander_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tlqe_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint unsigned ZERO_SQ = ((64'd1 << (2 * FB)) - 1) / 64'd1000000000000;
    localparam int LATENCY = 80;

    typedef struct packed {
        logic [COLW-1:0] blue;
        logic [COLW-1:0] green;
        logic [COLW-1:0] red;
        logic [THW-1:0]  thick;
        logic [CW-1:0]   ey;
        logic [CW-1:0]   ex;
        logic [CW-1:0]   sy;
        logic [CW-1:0]   sx;
    } t_segment;

    typedef struct packed {
        logic            last;
        logic [COLW-1:0] blue;
        logic [COLW-1:0] green;
        logic [COLW-1:0] red;
        logic [CW-1:0]   vy;
        logic [CW-1:0]   vx;
    } t_vertex;

    logic              clk;
    logic              rst_n;
    logic              s_valid;
    logic              s_ready;
    logic [IN_DW-1:0]  s_data;
    logic              m_valid;
    logic              m_ready;
    logic [OUT_DW-1:0] m_data;
    logic              m_last;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_idx;
    logic [CW-1:0]     cfg_data;

    // predictor copy of the registers
    longint          cam_x;
    longint          cam_y;
    longint unsigned zoom_val;

    t_vertex vertex_queue[$];
    int      error_count;
    bit      hold_off;
    bit      ready_free;

    thick_line_quad_expander_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // (world - camera) * zoom, rounded and saturated
    function automatic logic [CW-1:0] map_screen(longint w, longint c);
        longint d;
        longint unsigned m;
        longint unsigned r;
        d = w - c;
        m = (d < 0 ? longint'(-d) : d) * zoom_val;
        r = (m + (64'd1 << (FB - 1))) >> FB;
        if (d < 0) begin
            if (r > 64'h80000000) r = 64'h80000000;
            return 32'(-r);
        end
        if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
        return 32'(r);
    endfunction

    // queue the six vertices of one segment
    task automatic predict_quad(t_segment s);
        longint sx, sy, ex, ey, dx, dy, nx, ny;
        longint unsigned adx, ady, mx, len, nxm, nym;
        longint wx[4];
        longint wy[4];
        int corner[6];
        t_vertex v;
        corner = '{0, 1, 2, 0, 2, 3};
        sx = longint'($signed(s.sx));
        sy = longint'($signed(s.sy));
        ex = longint'($signed(s.ex));
        ey = longint'($signed(s.ey));
        dx = ex - sx;
        dy = ey - sy;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        mx = adx > ady ? adx : ady;
        if (mx < (64'd1 << 31)) begin
            if (adx * adx + ady * ady <= ZERO_SQ) return;
            while (mx < (64'd1 << 30)) begin
                mx <<= 1;
                adx <<= 1;
                ady <<= 1;
            end
        end else begin
            adx >>= 1;
            ady >>= 1;
        end
        len = int_sqrt(adx * adx + ady * ady);
        nxm = (ady * s.thick + len) / (2 * len);
        nym = (adx * s.thick + len) / (2 * len);
        nx = dy > 0 ? -longint'(nxm) : longint'(nxm);
        ny = dx < 0 ? -longint'(nym) : longint'(nym);
        wx[0] = sx + nx; wy[0] = sy + ny;
        wx[1] = ex + nx; wy[1] = ey + ny;
        wx[2] = ex - nx; wy[2] = ey - ny;
        wx[3] = sx - nx; wy[3] = sy - ny;
        for (int k = 0; k < 6; k++) begin
            v.vx = map_screen(wx[corner[k]], cam_x);
            v.vy = map_screen(wy[corner[k]], cam_y);
            v.red = s.red;
            v.green = s.green;
            v.blue = s.blue;
            v.last = (k == 5);
            vertex_queue.push_back(v);
        end
    endtask

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("vertex mismatch on %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off) m_ready <= 1'b0;
            else if (ready_free) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // vertex checker
    initial begin
        t_vertex got;
        t_vertex want;
        forever begin
            @(posedge clk);
            if (rst_n && m_valid && m_ready) begin
                got = {m_last, m_data[OUT_DW-1:0]};
                if (vertex_queue.size() == 0) begin
                    report_mismatch("unexpected vertex x", got.vx, '0);
                end else begin
                    want = vertex_queue.pop_front();
                    if (got.vx !== want.vx) report_mismatch("x", got.vx, want.vx);
                    if (got.vy !== want.vy) report_mismatch("y", got.vy, want.vy);
                    if (got.red !== want.red) report_mismatch("red", got.red, want.red);
                    if (got.green !== want.green)
                        report_mismatch("green", got.green, want.green);
                    if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
                    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
                end
            end
        end
    end

    // one register write; cfg_we then drops and the predictor copy is updated
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CW-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CAM_X: cam_x = longint'($signed(val));
            REG_CAM_Y: cam_y = longint'($signed(val));
            REG_ZOOM:  zoom_val = 64'(val[ZW-1:0]);
            default: ;
        endcase
    endtask

    // offer one segment and hold it until taken; an idle gap may follow
    task automatic send_segment(t_segment s, bit gap);
        s_valid <= 1'b1;
        s_data <= s;
        do @(posedge clk); while (!s_ready);
        predict_quad(s);
        if (gap) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain;
        while (vertex_queue.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic t_segment random_segment();
        t_segment s;
        int kind;
        s = IN_DW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            // short segment near the origin
            s.sx = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            s.sy = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            s.ex = s.sx + $signed($urandom_range(0, 32'h003FFFFF)) - 32'sh00200000;
            s.ey = s.sy + $signed($urandom_range(0, 32'h003FFFFF)) - 32'sh00200000;
            s.thick = THW'($urandom_range(0, 24'h0FFFFF));
        end else if (kind == 6) begin
            // tiny or zero length
            s.ex = s.sx + $signed($urandom_range(0, 2)) - 1;
            s.ey = s.sy + $signed($urandom_range(0, 2)) - 1;
        end else if (kind == 7) begin
            s.ey = s.sy;
        end
        return s;
    endfunction

    typedef struct {
        t_segment seg;
    } t_row;

    initial begin
        t_row rows[$];
        t_segment s;
        int unsigned burst;
        rst_n <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= REG_CAM_X;
        cfg_data <= '0;
        hold_off = 0;
        ready_free = 0;
        error_count = 0;
        cam_x = 0;
        cam_y = 0;
        zoom_val = 64'(ZOOM_RST);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: axis lines, zero length, extremes, colors
        rows.push_back('{'{8'h00, 8'h00, 8'h00, 24'h020000, 32'h0, 32'h00010000, 32'h0, 32'h0}});
        rows.push_back('{'{8'hFF, 8'hFF, 8'hFF, 24'h020000, 32'h00010000, 32'h0, 32'h0, 32'h0}});
        rows.push_back('{'{8'h12, 8'h34, 8'h56, 24'h010000, 32'h5, 32'h7, 32'h5, 32'h7}});
        rows.push_back('{'{8'h01, 8'h02, 8'h03, 24'hFFFFFF, 32'h1, 32'h0, 32'h0, 32'h0}});
        rows.push_back('{'{8'hA5, 8'h5A, 8'hC3, 24'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           32'h80000000, 32'h80000000}});
        rows.push_back('{'{8'h3C, 8'hC3, 8'h0F, 24'h0, 32'h80000000, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 32'h80000000}});
        rows.push_back('{'{8'hF0, 8'h0F, 8'h55, 24'h000001, 32'hFFFF0000, 32'h00030000,
                           32'h00020000, 32'hFFFE0000}});
        rows.push_back('{'{8'h77, 8'h88, 8'h99, 24'h800000, 32'h80000000, 32'h0,
                           32'h7FFFFFFF, 32'h0}});
        foreach (rows[i]) send_segment(rows[i].seg, 1'b0);
        s_valid <= 1'b0;
        drain();

        // random phases with different camera and zoom settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(REG_ZOOM, 32'hFFFFFF); write_reg(REG_CAM_X, 32'h7FFFFFFF);
                         write_reg(REG_CAM_Y, 32'h80000000); end
                1: begin write_reg(REG_ZOOM, 32'h0); write_reg(REG_CAM_X, 32'h0); end
                2: begin write_reg(REG_ZOOM, $urandom_range(0, 24'h04FFFF));
                         write_reg(REG_CAM_X, $urandom); write_reg(REG_CAM_Y, $urandom); end
                3: begin write_reg(REG_ZOOM, 32'h010000); write_reg(REG_CAM_X, 32'h00100000);
                         write_reg(REG_CAM_Y, 32'hFFF00000); end
                default: begin write_reg(REG_ZOOM, $urandom_range(0, 24'hFFFFFF)); end
            endcase
            ready_free = (phase == 3);
            burst = $urandom_range(1, 8);
            for (int n = 0; n < 52; n++) begin
                if (phase == 2 && n == 10) begin
                    fork
                        begin
                            hold_off = 1;
                            repeat (300) @(posedge clk);
                            hold_off = 0;
                        end
                    join_none
                end
                s = random_segment();
                burst--;
                send_segment(s, burst == 0);
                if (burst == 0) burst = $urandom_range(1, 8);
            end
            s_valid <= 1'b0;
            drain();
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/tlqe_pkg.sv
rtl/tlqe_sqrt.sv
rtl/tlqe_div.sv
rtl/tlqe_emit.sv
rtl/thick_line_quad_expander_core.sv
sim/thick_line_quad_expander_core_test.sv
